// File: sv/dag_pkg.sv
// Shared types and constants for the distance attenuation gain block.
// No dependencies; imported by every module of the block.
package dag_pkg;

  // Attenuation laws; codes 6 and 7 act as unity.
  typedef enum logic [2:0] {
    MODEL_NONE       = 3'd0,
    MODEL_LINEAR     = 3'd1,
    MODEL_INVERSE    = 3'd2,
    MODEL_INV_SQUARE = 3'd3,
    MODEL_LOG        = 3'd4,
    MODEL_CUSTOM     = 3'd5
  } model_e;

  localparam int CFG_IDX_W = 3;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MODEL   = 3'd0,
    REG_REF     = 3'd1,
    REG_FAR     = 3'd2,
    REG_ROLLOFF = 3'd3,
    REG_FLOOR   = 3'd4,
    REG_CEILING = 3'd5
  } cfg_reg_e;

  localparam int ROLL_W    = 16;  // rolloff, Q8.8
  localparam int ROLL_FRAC = 8;
  localparam int LOG_FRAC  = 16;  // log2 fraction bits
  localparam int SQ_LIM    = 46;  // squared distances scaled below 2^46
  localparam int X_W       = 46;  // multiplier operand for rolloff
  localparam int X_HALF    = 23;
  localparam int DEN_W     = 64;  // divider numerator/denominator

  // Control that travels with each beat into the divider.
  typedef struct packed {
    logic valid;
    logic byp;    // gain already known, divider result ignored
  } div_ctl_t;

endpackage

// File: sv/distance_attenuation_gain.sv
// Top level of the distance attenuation gain block: configuration registers,
// pipeline stall control, gain clamp and output register.
// Depends on dag_pkg, dag_prep and dag_div.
//
//  channel   dir  handshake                  payload
//  config    in   cfg_we_i                   cfg_index_i, cfg_data_i
//  distance  in   in_valid_i / in_ready_o    distance_in_i
//  gain      out  out_valid_o / out_ready_i  gain_out_o
//
// One distance per cycle while the output is not stalled. The path runs through
// six front stages, one divider entry stage, one stage per quotient bit of
// the restoring divider (GAIN_WIDTH-2), and the output register.
// Reset clears all valid bits and loads the register defaults.
// The whole pipeline holds while a gain beat waits on out_ready_i; in_ready_o
// is high whenever the output register is empty or being taken.
module distance_attenuation_gain #(
  parameter int DIST_WIDTH     = 24,
  parameter int GAIN_WIDTH     = 16,
  parameter int LOG_TABLE_BITS = 8
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [dag_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [((DIST_WIDTH > GAIN_WIDTH) ? DIST_WIDTH : GAIN_WIDTH)-1:0] cfg_data_i,
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [DIST_WIDTH-1:0]           distance_in_i,
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic [GAIN_WIDTH-1:0]           gain_out_o
);
  import dag_pkg::*;

  localparam int DW = DIST_WIDTH;
  localparam int GW = GAIN_WIDTH;

  model_e         model_q;
  logic [DW-1:0]  ref_q, far_q;
  logic [15:0]    rolloff_q;
  logic [GW-1:0]  floor_q, ceil_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      model_q   <= MODEL_INV_SQUARE;
      ref_q     <= DW'(32'd4096);
      far_q     <= DW'(32'd409600);
      rolloff_q <= 16'd256;
      floor_q   <= '0;
      ceil_q    <= GW'(32'd16384);
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_MODEL:   model_q   <= model_e'(cfg_data_i[2:0]);
        REG_REF:     ref_q     <= cfg_data_i[DW-1:0];
        REG_FAR:     far_q     <= cfg_data_i[DW-1:0];
        REG_ROLLOFF: rolloff_q <= cfg_data_i[15:0];
        REG_FLOOR:   floor_q   <= cfg_data_i[GW-1:0];
        REG_CEILING: ceil_q    <= cfg_data_i[GW-1:0];
        default:     ;
      endcase
    end
  end

  logic          en;
  logic          out_v_q;
  logic [GW-1:0] gain_q;

  assign en         = !out_v_q || out_ready_i;
  assign in_ready_o = en;

  div_ctl_t      pctl;
  logic [GW-1:0] pbg;
  logic [63:0]   pnum, pden;

  dag_prep #(
    .DW (DW),
    .GW (GW),
    .TB (LOG_TABLE_BITS)
  ) u_prep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .en_i      (en),
    .valid_i   (in_valid_i),
    .dist_i    (distance_in_i),
    .model_i   (model_q),
    .ref_i     (ref_q),
    .far_i     (far_q),
    .rolloff_i (rolloff_q),
    .floor_i   (floor_q),
    .ctl_o     (pctl),
    .bgain_o   (pbg),
    .num_o     (pnum),
    .den_o     (pden)
  );

  logic          dv;
  logic [GW-1:0] dgain;

  dag_div #(
    .GW (GW)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (pctl),
    .bgain_i (pbg),
    .num_i   (pnum),
    .den_i   (pden),
    .valid_o (dv),
    .gain_o  (dgain)
  );

  // floor first, ceiling wins when they cross
  logic [GW-1:0] g_lo, g_clamp;

  always_comb begin
    g_lo    = (dgain < floor_q) ? floor_q : dgain;
    g_clamp = (g_lo > ceil_q) ? ceil_q : g_lo;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_v_q <= 1'b0;
    else if (en) out_v_q <= dv;
  end

  always_ff @(posedge clk_i) begin
    if (en) gain_q <= g_clamp;
  end

  assign out_valid_o = out_v_q;
  assign gain_out_o  = gain_q;

endmodule

// File: sv/dag_prep.sv
// Front pipeline: distance squares, leading-one search, log table, rolloff
// products and law selection. Six register stages. Depends on dag_pkg.
module dag_prep #(
  parameter int DW = 24,
  parameter int GW = 16,
  parameter int TB = 8
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    en_i,
  input  logic                    valid_i,
  input  logic [DW-1:0]           dist_i,
  input  dag_pkg::model_e         model_i,
  input  logic [DW-1:0]           ref_i,
  input  logic [DW-1:0]           far_i,
  input  logic [15:0]             rolloff_i,
  input  logic [GW-1:0]           floor_i,
  output dag_pkg::div_ctl_t       ctl_o,
  output logic [GW-1:0]           bgain_o,
  output logic [63:0]             num_o,
  output logic [63:0]             den_o
);
  import dag_pkg::*;

  localparam int GF     = GW - 2;
  localparam int MSB_W  = $clog2(DW);
  localparam int SQ_W   = 2 * DW;
  localparam int LV_W   = MSB_W + LOG_FRAC;
  localparam int PL_W   = ROLL_W + LV_W;
  localparam int P_W    = ROLL_W + X_HALF;
  localparam int AMT_SH = ROLL_FRAC + LOG_FRAC - GF;
  localparam int TAB_N  = 1 << TB;
  localparam logic [GW-1:0] UNITY = GW'(1 << GF);

  // log2(1 + i/2^TB) by repeated squaring in Q1.30, built at elaboration
  function automatic logic [TAB_N*LOG_FRAC-1:0] build_log_tab();
    logic [TAB_N*LOG_FRAC-1:0] t;
    logic [63:0]               x;
    logic [LOG_FRAC-1:0]       r;
    t = '0;
    for (int i = 0; i < TAB_N; i++) begin
      x = 64'(TAB_N + i) << (30 - TB);
      r = '0;
      for (int k = 0; k < LOG_FRAC; k++) begin
        x = (x * x) >> 30;
        r = {r[LOG_FRAC-2:0], 1'b0};
        if (x >= (64'd2 << 30)) begin
          x    = x >> 1;
          r[0] = 1'b1;
        end
      end
      t[i*LOG_FRAC +: LOG_FRAC] = r;
    end
    return t;
  endfunction

  localparam logic [TAB_N*LOG_FRAC-1:0] LOG_TAB = build_log_tab();

  function automatic logic [MSB_W-1:0] lead_one(input logic [DW-1:0] v);
    logic [MSB_W-1:0] p;
    p = '0;
    for (int i = 0; i < DW; i++) begin
      if (v[i]) p = MSB_W'(i);
    end
    return p;
  endfunction

  // stage 1: input capture, zero distance becomes one LSB
  logic          s1_v_q;
  logic [DW-1:0] s1_d_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s1_v_q <= 1'b0;
    else if (en_i) s1_v_q <= valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) s1_d_q <= (dist_i == '0) ? DW'(1) : dist_i;
  end

  // stage 2: compares, differences, squares, leading ones
  logic             s2_v_q, s2_gt_q, s2_far_q, s2_rz_q;
  logic [DW-1:0]    s2_d_q, s2_dr_q, s2_fd_q, s2_fr_q;
  logic [SQ_W-1:0]  s2_d2_q, s2_r2_q;
  logic [MSB_W-1:0] s2_msb_d_q, s2_msb_r_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s2_v_q <= 1'b0;
    else if (en_i) s2_v_q <= s1_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s2_d_q     <= s1_d_q;
      s2_gt_q    <= s1_d_q > ref_i;
      s2_far_q   <= s1_d_q >= far_i;
      s2_rz_q    <= ref_i == '0;
      s2_dr_q    <= s1_d_q - ref_i;
      s2_fd_q    <= far_i - s1_d_q;
      s2_fr_q    <= far_i - ref_i;
      s2_d2_q    <= SQ_W'(s1_d_q) * SQ_W'(s1_d_q);
      s2_r2_q    <= SQ_W'(ref_i) * SQ_W'(ref_i);
      s2_msb_d_q <= lead_one(s1_d_q);
      s2_msb_r_q <= lead_one(ref_i);
    end
  end

  // stage 3: square scaling shift, log table indexes
  logic [MSB_W:0]   top_idx;
  logic [6:0]       blen, sh_d;
  logic [DW-1:0]    norm_d, norm_r;
  logic             s3_v_q, s3_gt_q, s3_far_q, s3_rz_q;
  logic [DW-1:0]    s3_dr_q, s3_fd_q, s3_fr_q;
  logic [SQ_W-1:0]  s3_d2_q, s3_r2_q;
  logic [MSB_W-1:0] s3_msb_d_q, s3_msb_r_q;
  logic [6:0]       s3_sh_q;
  logic [TB-1:0]    s3_idx_d_q, s3_idx_r_q;

  always_comb begin
    top_idx = {s2_msb_d_q, 1'b1};
    blen    = 7'(top_idx) + 7'(s2_d2_q[top_idx]);
    sh_d    = (blen > 7'(SQ_LIM)) ? blen - 7'(SQ_LIM) : 7'd0;
    norm_d  = s2_d_q << (MSB_W'(DW - 1) - s2_msb_d_q);
    norm_r  = ref_i << (MSB_W'(DW - 1) - s2_msb_r_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s3_v_q <= 1'b0;
    else if (en_i) s3_v_q <= s2_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s3_gt_q    <= s2_gt_q;
      s3_far_q   <= s2_far_q;
      s3_rz_q    <= s2_rz_q;
      s3_dr_q    <= s2_dr_q;
      s3_fd_q    <= s2_fd_q;
      s3_fr_q    <= s2_fr_q;
      s3_d2_q    <= s2_d2_q;
      s3_r2_q    <= s2_r2_q;
      s3_msb_d_q <= s2_msb_d_q;
      s3_msb_r_q <= s2_msb_r_q;
      s3_sh_q    <= sh_d;
      s3_idx_d_q <= norm_d[DW-2 -: TB];
      s3_idx_r_q <= norm_r[DW-2 -: TB];
    end
  end

  // stage 4: scaled squares, log difference
  logic [63:0]      n2w, x2w;
  logic [LV_W-1:0]  ld, lr;
  logic             s4_v_q, s4_gt_q, s4_far_q, s4_rz_q;
  logic [DW-1:0]    s4_dr_q, s4_fd_q, s4_fr_q;
  logic [X_W-1:0]   s4_n2_q, s4_x2_q;
  logic [LV_W-1:0]  s4_l_q;

  always_comb begin
    n2w = 64'(s3_r2_q) >> s3_sh_q;
    x2w = 64'(s3_d2_q - s3_r2_q) >> s3_sh_q;
    ld  = {s3_msb_d_q, LOG_TAB[s3_idx_d_q*LOG_FRAC +: LOG_FRAC]};
    lr  = {s3_msb_r_q, LOG_TAB[s3_idx_r_q*LOG_FRAC +: LOG_FRAC]};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s4_v_q <= 1'b0;
    else if (en_i) s4_v_q <= s3_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s4_gt_q  <= s3_gt_q;
      s4_far_q <= s3_far_q;
      s4_rz_q  <= s3_rz_q;
      s4_dr_q  <= s3_dr_q;
      s4_fd_q  <= s3_fd_q;
      s4_fr_q  <= s3_fr_q;
      s4_n2_q  <= n2w[X_W-1:0];
      s4_x2_q  <= x2w[X_W-1:0];
      s4_l_q   <= (ld > lr) ? ld - lr : '0;
    end
  end

  // stage 5: numerator pick and rolloff products (operand split in halves)
  logic [63:0]     num_d;
  logic [X_W-1:0]  x_d;
  logic            s5_v_q, s5_gt_q, s5_far_q, s5_rz_q;
  logic [DW-1:0]   s5_fr_q;
  logic [63:0]     s5_num_q;
  logic [P_W-1:0]  s5_plo_q, s5_phi_q;
  logic [PL_W-1:0] s5_plog_q;

  always_comb begin
    case (model_i)
      MODEL_LINEAR: begin
        num_d = 64'(s4_fd_q);
        x_d   = X_W'(s4_dr_q);
      end
      MODEL_INVERSE: begin
        num_d = 64'({ref_i, 8'b0});
        x_d   = X_W'(s4_dr_q);
      end
      default: begin
        num_d = 64'({s4_n2_q, 8'b0});
        x_d   = s4_x2_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s5_v_q <= 1'b0;
    else if (en_i) s5_v_q <= s4_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s5_gt_q   <= s4_gt_q;
      s5_far_q  <= s4_far_q;
      s5_rz_q   <= s4_rz_q;
      s5_fr_q   <= s4_fr_q;
      s5_num_q  <= num_d;
      s5_plo_q  <= P_W'(rolloff_i) * P_W'(x_d[X_HALF-1:0]);
      s5_phi_q  <= P_W'(rolloff_i) * P_W'(x_d[X_W-1:X_HALF]);
      s5_plog_q <= PL_W'(rolloff_i) * PL_W'(s4_l_q);
    end
  end

  // stage 6: denominator sum, laws that need no division
  logic [63:0]     den_d;
  logic [PL_W-1:0] amt;
  logic            byp_d;
  logic [GW-1:0]   bg_d;
  logic            s6_v_q, s6_byp_q;
  logic [GW-1:0]   s6_bg_q;
  logic [63:0]     s6_num_q, s6_den_q;

  always_comb begin
    amt   = s5_plog_q >> AMT_SH;
    den_d = s5_num_q + 64'(s5_plo_q) + (64'(s5_phi_q) << X_HALF);
    byp_d = 1'b1;
    bg_d  = UNITY;
    if (s5_gt_q) begin
      case (model_i)
        MODEL_LINEAR: begin
          den_d = 64'(s5_fr_q);
          byp_d = s5_far_q;
          bg_d  = floor_i;
        end
        MODEL_INVERSE, MODEL_INV_SQUARE, MODEL_CUSTOM: begin
          byp_d = 1'b0;
        end
        MODEL_LOG: begin
          if (s5_rz_q || amt >= PL_W'(UNITY)) bg_d = '0;
          else bg_d = UNITY - GW'(amt);
        end
        default: begin
          bg_d = UNITY;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) s6_v_q <= 1'b0;
    else if (en_i) s6_v_q <= s5_v_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s6_byp_q <= byp_d;
      s6_bg_q  <= bg_d;
      s6_num_q <= s5_num_q;
      s6_den_q <= den_d;
    end
  end

  assign ctl_o.valid = s6_v_q;
  assign ctl_o.byp   = s6_byp_q;
  assign bgain_o     = s6_bg_q;
  assign num_o       = s6_num_q;
  assign den_o       = s6_den_q;

endmodule

// File: sv/dag_div.sv
// Pipelined restoring divider: floor(num * unity / den), one quotient bit
// per stage, with a pass-through for gains already known. Depends on dag_pkg.
module dag_div #(
  parameter int GW = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  dag_pkg::div_ctl_t ctl_i,
  input  logic [GW-1:0]     bgain_i,
  input  logic [63:0]       num_i,
  input  logic [63:0]       den_i,
  output logic              valid_o,
  output logic [GW-1:0]     gain_o
);
  import dag_pkg::*;

  localparam int GF = GW - 2;
  localparam logic [GW-1:0] UNITY = GW'(1 << GF);

  logic              v_q   [GF+1];
  logic              byp_q [GF+1];
  logic [GW-1:0]     bg_q  [GF+1];
  logic [DEN_W-1:0]  rem_q [GF+1];
  logic [DEN_W-1:0]  den_q [GF+1];
  logic [GF-1:0]     quo_q [GF+1];

  // entry stage: zero denominator and full-scale cases
  logic          byp0;
  logic [GW-1:0] bg0;

  always_comb begin
    byp0 = ctl_i.byp;
    bg0  = bgain_i;
    if (!ctl_i.byp) begin
      if (den_i == '0) begin
        byp0 = 1'b1;
        bg0  = '0;
      end else if (num_i >= den_i) begin
        byp0 = 1'b1;
        bg0  = UNITY;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v_q[0] <= 1'b0;
    else if (en_i) v_q[0] <= ctl_i.valid;
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      byp_q[0] <= byp0;
      bg_q[0]  <= bg0;
      rem_q[0] <= num_i;
      den_q[0] <= den_i;
      quo_q[0] <= '0;
    end
  end

  for (genvar k = 0; k < GF; k++) begin : g_step
    logic [DEN_W:0] shl;
    logic           ge;

    assign shl = {rem_q[k], 1'b0};
    assign ge  = shl >= {1'b0, den_q[k]};

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) v_q[k+1] <= 1'b0;
      else if (en_i) v_q[k+1] <= v_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        byp_q[k+1] <= byp_q[k];
        bg_q[k+1]  <= bg_q[k];
        den_q[k+1] <= den_q[k];
        rem_q[k+1] <= ge ? DEN_W'(shl - {1'b0, den_q[k]}) : DEN_W'(shl);
        quo_q[k+1] <= {quo_q[k][GF-2:0], ge};
      end
    end
  end

  assign valid_o = v_q[GF];
  assign gain_o  = byp_q[GF] ? bg_q[GF] : GW'(quo_q[GF]);

endmodule

// File: tb/tb_distance_attenuation_gain.sv
// Self-checking testbench for distance_attenuation_gain: directed and random
// distances under every attenuation law. Depends on dag_pkg and the block's RTL.
module tb_distance_attenuation_gain;
  import dag_pkg::*;

  localparam int DW = 24;
  localparam int GW = 16;
  localparam int TB = 8;
  localparam int FRAC = GW - 2;
  localparam longint unsigned UNITY = 64'd1 << FRAC;
  localparam int LATENCY = GW + 6;
  localparam int WD_LIMIT = 4000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  cfg_reg_e cfg_index_i = REG_MODEL;
  logic [DW-1:0] cfg_data_i = '0;
  logic in_valid_i = 1'b0;
  logic in_ready_o;
  logic [DW-1:0] distance_in_i = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  logic [GW-1:0] gain_out_o;

  distance_attenuation_gain dut (
    .clk_i(clk_i), .rst_ni(rst_ni), .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i), .in_valid_i(in_valid_i), .in_ready_o(in_ready_o),
    .distance_in_i(distance_in_i), .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i), .gain_out_o(gain_out_o)
  );

  initial forever #6 clk_i = ~clk_i;

  // predictor copy of the registers
  logic [2:0] law_q;
  longint unsigned ref_q, far_q, roll_q, floor_q, ceil_q;
  logic [GW-1:0] gain_fifo[$];
  int errors = 0;
  int n_sent = 0;
  int n_recv = 0;
  int idle_cnt = 0;
  bit hold_rx = 1'b0;
  bit rx_done = 1'b0;

  function automatic longint unsigned unit_quot(longint unsigned n, longint unsigned den);
    longint unsigned rem, q;
    rem = n;
    q = 0;
    if (den == 0) return 0;
    if (n >= den) return UNITY;
    for (int k = 0; k < FRAC; k++) begin
      rem = rem << 1;
      q = q << 1;
      if (rem >= den) begin
        rem -= den;
        q |= 1;
      end
    end
    return q;
  endfunction

  // log2(1 + idx/2^TB) by repeated squaring in Q1.30
  function automatic longint unsigned log_frac(longint unsigned idx);
    longint unsigned x, r;
    x = ((64'd1 << TB) + idx) << (30 - TB);
    r = 0;
    for (int k = 0; k < 16; k++) begin
      x = (x * x) >> 30;
      r = r << 1;
      if (x >= (64'd2 << 30)) begin
        x = x >> 1;
        r |= 1;
      end
    end
    return r;
  endfunction

  function automatic longint unsigned log2_q16(longint unsigned v);
    int msb;
    longint unsigned idx;
    msb = 0;
    while (msb < 63 && (v >> (msb + 1)) != 0) msb++;
    if (msb >= TB) idx = (v >> (msb - TB)) & ((64'd1 << TB) - 1);
    else idx = (v << (TB - msb)) & ((64'd1 << TB) - 1);
    return (longint'(msb) << 16) + log_frac(idx);
  endfunction

  function automatic logic [GW-1:0] predict_gain(logic [DW-1:0] dval);
    longint unsigned d, r, g, d2, r2, n, ld, lr, l, amt;
    int s;
    d = dval;
    r = ref_q;
    g = UNITY;
    if (d == 0) d = 1;
    if (law_q >= MODEL_LINEAR && law_q <= MODEL_CUSTOM && d > r) begin
      case (law_q)
        MODEL_LINEAR: begin
          if (d >= far_q) g = floor_q;
          else g = unit_quot(far_q - d, far_q - r);
        end
        MODEL_INVERSE: g = unit_quot(r << 8, (r << 8) + roll_q * (d - r));
        MODEL_LOG: begin
          if (r == 0) g = 0;
          else begin
            ld = log2_q16(d);
            lr = log2_q16(r);
            l = (ld > lr) ? ld - lr : 0;
            amt = (roll_q * l) >> (8 + 16 - FRAC);
            g = (amt >= UNITY) ? 0 : UNITY - amt;
          end
        end
        default: begin
          d2 = d * d;
          r2 = r * r;
          s = 0;
          while ((d2 >> s) >= (64'd1 << 46)) s++;
          n = (r2 >> s) << 8;
          g = unit_quot(n, n + roll_q * ((d2 - r2) >> s));
        end
      endcase
    end
    if (g < floor_q) g = floor_q;
    if (g > ceil_q) g = ceil_q;
    return g[GW-1:0];
  endfunction

  task automatic write_reg(cfg_reg_e idx, longint unsigned val);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= val[DW-1:0];
    case (idx)
      REG_MODEL:   law_q = val[2:0];
      REG_REF:     ref_q = val[DW-1:0];
      REG_FAR:     far_q = val[DW-1:0];
      REG_ROLLOFF: roll_q = val[15:0];
      REG_FLOOR:   floor_q = val[GW-1:0];
      default:     ceil_q = val[GW-1:0];
    endcase
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_all(logic [2:0] law, longint unsigned r, longint unsigned f,
                         longint unsigned ro, longint unsigned fl, longint unsigned ce);
    write_reg(REG_MODEL, law);
    write_reg(REG_REF, r);
    write_reg(REG_FAR, f);
    write_reg(REG_ROLLOFF, ro);
    write_reg(REG_FLOOR, fl);
    write_reg(REG_CEILING, ce);
  endtask

  // sender: random idle gap or none, then one beat; valid stays up across gapless beats
  task automatic send_distance(logic [DW-1:0] dval, bit gaps = 1'b1);
    int gap;
    gap = gaps ? $urandom_range(0, 11) : 0;
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap != 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    distance_in_i <= dval;
    gain_fifo.push_back(predict_gain(dval));
    do @(posedge clk_i); while (!in_ready_o);
    n_sent++;
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (gain_fifo.size() != 0) @(posedge clk_i);
    repeat (LATENCY + 4) @(posedge clk_i);
  endtask

  function automatic logic [DW-1:0] rand_distance();
    case ($urandom_range(0, 3))
      0: return DW'($urandom_range(0, 8191));
      1: return DW'($urandom_range(0, 1 << 20));
      2: return DW'(1) << $urandom_range(0, DW - 1);
      default: return DW'($urandom());
    endcase
  endfunction

  // receiver: random wait per beat, long hold-off on request
  initial begin
    int stall;
    stall = 0;
    while (!rx_done) begin
      @(posedge clk_i);
      if (out_valid_o && out_ready_i)
        stall = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 11);
      if (hold_rx) out_ready_i <= 1'b0;
      else if (stall > 0) begin
        out_ready_i <= 1'b0;
        stall--;
      end else out_ready_i <= 1'b1;
    end
  end

  // result check and watchdog
  always @(posedge clk_i) begin
    logic [GW-1:0] want;
    if (rst_ni) begin
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) || hold_rx)
        idle_cnt <= 0;
      else idle_cnt <= idle_cnt + 1;
      if (out_valid_o && out_ready_i) begin
        n_recv++;
        if (gain_fifo.size() == 0) begin
          errors++;
          $display("%0t: unexpected gain beat %0d", $time, gain_out_o);
        end else begin
          want = gain_fifo.pop_front();
          if (want !== gain_out_o) begin
            errors++;
            $display("%0t: gain mismatch expected %0d actual %0d", $time, want, gain_out_o);
          end
        end
      end
      if (idle_cnt >= WD_LIMIT) begin
        $display("%0t: watchdog expired, %0d gains outstanding", $time, gain_fifo.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  task automatic test_defaults();
    logic [DW-1:0] pts[10] = '{0, 1, 4095, 4096, 4097, 8192, 409600, 24'hFFFFFF,
                               24'h800000, 24'h000FFF};
    foreach (pts[i]) send_distance(pts[i]);
    drain();
  endtask

  task automatic test_laws();
    for (int m = 0; m < 8; m++) begin
      drain();
      write_reg(REG_MODEL, m);
      send_distance(0);
      send_distance(DW'(ref_q + 1));
      send_distance(24'hFFFFFF);
    end
    drain();
  endtask

  task automatic test_corners();
    // zero reference, far not above reference, floor above ceiling
    set_all(MODEL_LOG, 0, 0, 16'hFFFF, 0, 16'hFFFF);
    send_distance(5);
    drain();
    write_reg(REG_MODEL, MODEL_INVERSE);
    send_distance(24'hFFFFFF);
    drain();
    set_all(MODEL_LINEAR, 8192, 4096, 256, 100, 16384);
    send_distance(9000);
    send_distance(24'hFFFFFF);
    drain();
    set_all(MODEL_INV_SQUARE, 24'hFFFFFF, 24'hFFFFFF, 0, 20000, 300);
    send_distance(24'hFFFFFF);
    send_distance(3);
    drain();
  endtask

  task automatic test_random(int n);
    for (int k = 0; k < n; k++) begin
      if (k % 100 == 0) begin
        drain();
        set_all($urandom_range(0, 7),
                ($urandom_range(0, 1)) ? $urandom_range(0, 65536) : $urandom(),
                ($urandom_range(0, 1)) ? $urandom_range(0, 1 << 21) : $urandom(),
                ($urandom_range(0, 3) == 0) ? 16'hFFFF : $urandom_range(0, 2048),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(0, 2000),
                ($urandom_range(0, 3) == 0) ? $urandom() : $urandom_range(8000, 16384));
      end
      send_distance(rand_distance(), (k % 200) > 60);
    end
    drain();
  endtask

  task automatic test_backpressure();
    hold_rx = 1'b1;
    fork
      begin
        for (int c = 0; c < 200; c++) @(posedge clk_i);
        hold_rx = 1'b0;
      end
      for (int k = 0; k < 60; k++) send_distance(rand_distance(), 1'b0);
    join
    drain();
  endtask

  initial begin
    law_q = MODEL_INV_SQUARE;
    ref_q = 4096;
    far_q = 409600;
    roll_q = 256;
    floor_q = 0;
    ceil_q = 16384;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_defaults();
    test_laws();
    test_corners();
    test_backpressure();
    test_random(1150);
    rx_done = 1'b1;
    $display("Sent %0d distances over all eight law codes, %0d gains checked.",
             n_sent, n_recv);
    $display("Covered register extremes, clamp corners and a full-pipeline stall.");
    if (errors == 0 && gain_fifo.size() == 0) $display("[ OK ] regression clean");
    else $display("[FAIL] regression broken");
    $finish;
  end
endmodule
